/* rtl/mqf_pkg.sv */
// ----------------------------------------------------------------------------
// mqf_pkg
// Shared types and constants of the multi-queue FIFO with drop count.
// ----------------------------------------------------------------------------
package mqf_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int QUEUE_COUNT  = 4;
    localparam int WORD_WIDTH   = 32;

    localparam int QIDX_W       = 2;
    localparam int DATA_W       = 32;
    localparam int LOST_W       = 32;
    localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int WORD_ENTRIES = QUEUE_COUNT << PTR_W;
    localparam int WADDR_W      = (WORD_ENTRIES > 1) ? $clog2(WORD_ENTRIES) : 1;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_POP   = 2'd1,
        OP_PUSH  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_FETCH
    } fsm_t;

    typedef struct packed {
        logic [PTR_W-1:0]  rd_ptr;
        logic [PTR_W-1:0]  wr_ptr;
        logic [CNT_W-1:0]  count;
        logic [LOST_W-1:0] lost;
    } qstate_t;

    typedef struct packed {
        logic              rd_en;
        logic [QIDX_W-1:0] rd_addr;
        logic              wr_en;
        logic [QIDX_W-1:0] wr_addr;
        qstate_t           wr_data;
    } qstate_req_t;

    typedef struct packed {
        logic                  rd_en;
        logic [WADDR_W-1:0]    rd_addr;
        logic                  wr_en;
        logic [WADDR_W-1:0]    wr_addr;
        logic [WORD_WIDTH-1:0] wr_data;
    } word_req_t;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [DATA_W-1:0] widen_word(input logic [WORD_WIDTH-1:0] w);
        return DATA_W'($signed(w));
    endfunction

    function automatic logic [WORD_WIDTH-1:0] narrow_word(input logic [DATA_W-1:0] d);
        return WORD_WIDTH'($signed(d));
    endfunction

endpackage

/* rtl/mqf_word_ram.sv */
// ----------------------------------------------------------------------------
// mqf_word_ram
// Word store of all queues: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mqf_word_ram (
    input  logic                          clk,
    input  mqf_pkg::word_req_t            req,
    output logic [mqf_pkg::WORD_WIDTH-1:0] rd_data
);
    import mqf_pkg::*;

    logic [WORD_WIDTH-1:0] mem [WORD_ENTRIES];
    logic [WORD_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/mqf_qstate_mem.sv */
// ----------------------------------------------------------------------------
// mqf_qstate_mem
// Per-queue pointers, fill count and lost count, with a registered read.
// Entries not yet written since reset read as zero.
// ----------------------------------------------------------------------------
module mqf_qstate_mem (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mqf_pkg::qstate_req_t req,
    output mqf_pkg::qstate_t     rd_data
);
    import mqf_pkg::*;

    qstate_t               mem [QUEUE_COUNT];
    logic [QUEUE_COUNT-1:0] valid_reg;
    qstate_t               rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= valid_reg[req.rd_addr] ? mem[req.rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/mqf_ctrl.sv */
// ----------------------------------------------------------------------------
// mqf_ctrl
// Request sequencer: read queue state, update it, fetch or store the word,
// and register the result.
// ----------------------------------------------------------------------------
module mqf_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    operation,
    input  logic [mqf_pkg::QIDX_W-1:0]    queue,
    input  logic signed [mqf_pkg::DATA_W-1:0] push_data,
    output logic                          done,
    output logic signed [mqf_pkg::DATA_W-1:0] pop_data,
    output logic [1:0]                    status,
    output logic [mqf_pkg::CNT_W-1:0]     fill_level,
    output logic [mqf_pkg::LOST_W-1:0]    lost_count,
    output mqf_pkg::qstate_req_t          qs_req,
    input  mqf_pkg::qstate_t              qs_rd_data,
    output mqf_pkg::word_req_t            word_req,
    input  logic [mqf_pkg::WORD_WIDTH-1:0] word_rd_data
);
    import mqf_pkg::*;

    fsm_t                 state_reg, state_next;
    op_t                  op_reg;
    logic [QIDX_W-1:0]    q_reg;
    logic [DATA_W-1:0]    data_reg;

    logic                 done_reg, done_next;
    logic [DATA_W-1:0]    pop_data_reg;
    status_t              status_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic [LOST_W-1:0]    lost_reg;

    logic                 in_range;
    logic                 is_empty;
    logic                 is_full;
    logic                 pop_hit;
    qstate_t              upd;
    logic                 upd_write;
    status_t              upd_status;

    assign in_range = ({1'b0, q_reg} < (QIDX_W + 1)'(QUEUE_COUNT));
    assign is_empty = (qs_rd_data.count == '0);
    assign is_full  = (qs_rd_data.count >= CNT_W'(QUEUE_DEPTH));
    assign pop_hit  = in_range && (op_reg == OP_POP) && !is_empty;

    // Next queue state and status for the held request
    always_comb
    begin
        upd        = qs_rd_data;
        upd_write  = 1'b0;
        upd_status = ST_OK;
        case (op_reg)
            OP_CLEAR:
            begin
                upd       = '0;
                upd_write = 1'b1;
            end
            OP_POP:
            begin
                if (is_empty)
                begin
                    upd_status = ST_EMPTY;
                end
                else
                begin
                    upd.rd_ptr = next_slot(qs_rd_data.rd_ptr);
                    upd.count  = qs_rd_data.count - 1'b1;
                    upd_write  = 1'b1;
                end
            end
            OP_PUSH:
            begin
                upd_write = 1'b1;
                if (is_full)
                begin
                    upd_status = ST_FULL;
                    if (qs_rd_data.lost != '1)
                    begin
                        upd.lost = qs_rd_data.lost + 1'b1;
                    end
                end
                else
                begin
                    upd.wr_ptr = next_slot(qs_rd_data.wr_ptr);
                    upd.count  = qs_rd_data.count + 1'b1;
                end
            end
            default:
            begin
                upd_write = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = pop_hit ? S_FETCH : S_IDLE;
            end
            S_FETCH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        qs_req           = '0;
        word_req         = '0;
        done_next        = 1'b0;
        qs_req.rd_addr   = queue;
        qs_req.wr_addr   = q_reg;
        qs_req.wr_data   = upd;
        word_req.rd_addr = WADDR_W'({q_reg, qs_rd_data.rd_ptr});
        word_req.wr_addr = WADDR_W'({q_reg, qs_rd_data.wr_ptr});
        word_req.wr_data = narrow_word(data_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                qs_req.rd_en = start;
            end
            S_UPDATE:
            begin
                qs_req.wr_en   = in_range && upd_write;
                word_req.rd_en = pop_hit;
                word_req.wr_en = in_range && (op_reg == OP_PUSH) && !is_full;
                done_next      = !pop_hit;
            end
            S_FETCH:
            begin
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Hold the request and build the result
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg   <= op_t'(operation);
            q_reg    <= queue;
            data_reg <= push_data;
        end
        if (state_reg == S_UPDATE)
        begin
            pop_data_reg <= '0;
            if (in_range)
            begin
                status_reg <= upd_status;
                fill_reg   <= upd.count;
                lost_reg   <= upd.lost;
            end
            else
            begin
                status_reg <= ST_OK;
                fill_reg   <= '0;
                lost_reg   <= '0;
            end
        end
        if (state_reg == S_FETCH)
        begin
            pop_data_reg <= widen_word(word_rd_data);
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign pop_data   = pop_data_reg;
    assign status     = status_reg;
    assign fill_level = fill_reg;
    assign lost_count = lost_reg;

endmodule

/* rtl/multi_queue_fifo_with_drop_count.sv */
// ----------------------------------------------------------------------------
// multi_queue_fifo_with_drop_count
// Four circular FIFOs of 16 signed words each, sharing one word memory,
// with a saturating count of dropped pushes per queue.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Clear, push and
// empty-pop requests give their result on done two cycles after acceptance;
// a pop that returns a word takes three, one more for the word memory read.
// The result sits on the output ports for the single cycle that done is
// high and must be captured then. busy stays high until the request's
// state is written back, so a new request can be taken in the same cycle
// that done is high. The queue state table and the word memory, each with
// a one-cycle registered read, set these figures.
module multi_queue_fifo_with_drop_count (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    operation,
    input  logic [mqf_pkg::QIDX_W-1:0]    queue,
    input  logic signed [mqf_pkg::DATA_W-1:0] push_data,
    output logic                          done,
    output logic signed [mqf_pkg::DATA_W-1:0] pop_data,
    output logic [1:0]                    status,
    output logic [mqf_pkg::CNT_W-1:0]     fill_level,
    output logic [mqf_pkg::LOST_W-1:0]    lost_count
);
    import mqf_pkg::*;

    qstate_req_t           qs_req;
    qstate_t               qs_rd_data;
    word_req_t             word_req;
    logic [WORD_WIDTH-1:0] word_rd_data;

    mqf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .queue        (queue),
        .push_data    (push_data),
        .done         (done),
        .pop_data     (pop_data),
        .status       (status),
        .fill_level   (fill_level),
        .lost_count   (lost_count),
        .qs_req       (qs_req),
        .qs_rd_data   (qs_rd_data),
        .word_req     (word_req),
        .word_rd_data (word_rd_data)
    );

    mqf_qstate_mem u_qstate_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (qs_req),
        .rd_data (qs_rd_data)
    );

    mqf_word_ram u_word_ram (
        .clk     (clk),
        .req     (word_req),
        .rd_data (word_rd_data)
    );

endmodule
